// ===== sv/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// Types and constants shared by the mesh forward decision modules.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int unsigned CallW = 56;
  localparam int unsigned MsgW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned LvlW  = 9;

  localparam logic [1:0] RegMinLevel = 2'd0;
  localparam logic [1:0] RegTopCount = 2'd1;
  localparam logic [1:0] RegTimeout  = 2'd2;
  localparam logic [1:0] RegOffset   = 2'd3;

  localparam logic [2:0] StForwarded    = 3'd0;
  localparam logic [2:0] StShort        = 3'd1;
  localparam logic [2:0] StDuplicate    = 3'd2;
  localparam logic [2:0] StHopExpired   = 3'd3;
  localparam logic [2:0] StWeak         = 3'd4;
  localparam logic [2:0] StNotPreferred = 3'd5;
  localparam logic [2:0] StCleanupDone  = 3'd6;

  typedef struct packed {
    logic                    cleanup;
    logic                    short_frame;
    logic [CallW-1:0]        call;
    logic [MsgW-1:0]         msg;
    logic [7:0]              hop;
    logic signed [LvlW-1:0]  lvl;
    logic [TimeW-1:0]        t;
  } job_t;

  typedef struct packed {
    logic [2:0]             status;
    logic                   forward;
    logic [7:0]             new_hop;
    logic signed [LvlW-1:0] lvl;
    logic                   preferred;
  } res_t;

endpackage

// ===== sv/mfd_front.sv =====
// ----------------------------------------------------------------------------
// mfd_front
// Accepts input items, computes the level and the short-frame flag.
// ----------------------------------------------------------------------------
module mfd_front #(
  parameter int unsigned HEADER_BYTES = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cmd_i,
  input  logic [55:0]   call_i,
  input  logic [15:0]   msg_i,
  input  logic [7:0]    hop_i,
  input  logic [7:0]    len_i,
  input  logic [7:0]    raw_i,
  input  logic [31:0]   time_i,
  input  logic [7:0]    offset_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output mfd_pkg::job_t job_o
);
  import mfd_pkg::*;

  localparam logic [7:0] HdrLen = 8'(HEADER_BYTES);

  logic full_q, full_d;
  job_t job_q, job_d;

  assign in_ready_o  = !full_q || job_ready_i;
  assign job_valid_o = full_q;
  assign job_o       = job_q;

  always_comb begin
    full_d = full_q;
    job_d  = job_q;
    if (job_ready_i) full_d = 1'b0;
    if (in_valid_i && in_ready_o) begin
      full_d           = 1'b1;
      job_d.cleanup    = cmd_i;
      job_d.short_frame = len_i < HdrLen;
      job_d.call       = call_i;
      job_d.msg        = msg_i;
      job_d.hop        = hop_i;
      job_d.lvl        = cmd_i ? '0 : $signed({1'b0, raw_i}) - $signed({1'b0, offset_i});
      job_d.t          = time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else full_q <= full_d;
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

// ===== sv/mfd_back.sv =====
// ----------------------------------------------------------------------------
// mfd_back
// Scans the seen ring and neighbor table one entry a cycle (cleanup: table only).
// ----------------------------------------------------------------------------
module mfd_back #(
  parameter int unsigned SEEN_DEPTH = 32,
  parameter int unsigned PEER_SLOTS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  mfd_pkg::job_t        job_i,
  input  logic signed [8:0]    min_level_i,
  input  logic [4:0]           top_count_i,
  input  logic [31:0]          timeout_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output mfd_pkg::res_t        res_o
);
  import mfd_pkg::*;

  localparam int unsigned SW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int unsigned PW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(PEER_SLOTS + 1);
  localparam int unsigned SCW = $clog2(SEEN_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SEEN  = 8'b0000_0010,
    S_FIND  = 8'b0000_0100,
    S_WRITE = 8'b0000_1000,
    S_RANK  = 8'b0001_0000,
    S_CLEAN = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  job_t job_q;
  logic [SCW-1:0] sidx_q, sidx_d;
  logic [CW-1:0] pidx_q, pidx_d;
  logic [SW-1:0] snext_q, snext_d;
  logic [SEEN_DEPTH-1:0] svalid_q, svalid_d;
  logic [PEER_SLOTS-1:0] pvalid_q, pvalid_d;
  logic hit_q, hit_d, free_found_q, free_found_d;
  logic [PW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [CW-1:0] stronger_q, stronger_d;
  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;
  res_t acc_q, acc_d;

  logic [CallW-1:0] seen_src [SEEN_DEPTH];
  logic [MsgW-1:0]  seen_msg [SEEN_DEPTH];
  logic [CallW-1:0] peer_call [PEER_SLOTS];
  logic signed [LvlW-1:0] peer_lvl [PEER_SLOTS];
  logic [TimeW-1:0] peer_time [PEER_SLOTS];

  logic [SW-1:0] sa;
  logic [PW-1:0] pa;
  logic seen_wr, peer_wr;
  logic [PW-1:0] peer_wa;
  logic [TimeW-1:0] age;
  logic pref;

  assign sa = sidx_q[SW-1:0];
  assign pa = pidx_q[PW-1:0];
  assign age = job_q.t - peer_time[pa];
  assign pref = hit_q && (stronger_q < CW'(top_count_i));

  assign job_ready_o = state_q == S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    sidx_d = sidx_q;
    pidx_d = pidx_q;
    snext_d = snext_q;
    svalid_d = svalid_q;
    pvalid_d = pvalid_q;
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    free_found_d = free_found_q;
    free_idx_d = free_idx_q;
    stronger_d = stronger_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d = res_q;
    acc_d = acc_q;
    seen_wr = 1'b0;
    peer_wr = 1'b0;
    peer_wa = hit_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          sidx_d = '0;
          pidx_d = '0;
          hit_d = 1'b0;
          free_found_d = 1'b0;
          stronger_d = '0;
          acc_d.status = StForwarded;
          acc_d.forward = 1'b0;
          acc_d.new_hop = job_i.hop;
          acc_d.lvl = job_i.lvl;
          acc_d.preferred = 1'b0;
          if (job_i.cleanup) begin
            acc_d.status = StCleanupDone;
            state_d = S_CLEAN;
          end else if (job_i.short_frame) begin
            acc_d.status = StShort;
            state_d = S_OUT;
          end else begin
            state_d = S_SEEN;
          end
        end
      end
      S_SEEN: begin
        if (svalid_q[sa] && seen_src[sa] == job_q.call && seen_msg[sa] == job_q.msg) begin
          acc_d.status = StDuplicate;
          state_d = S_OUT;
        end else if (sidx_q == SCW'(SEEN_DEPTH - 1)) begin
          seen_wr = 1'b1;
          svalid_d[snext_q] = 1'b1;
          snext_d = (snext_q == SW'(SEEN_DEPTH - 1)) ? '0 : snext_q + 1'b1;
          state_d = S_FIND;
        end else begin
          sidx_d = sidx_q + 1'b1;
        end
      end
      S_FIND: begin
        if (pvalid_q[pa] && peer_call[pa] == job_q.call) begin
          hit_d = 1'b1;
          hit_idx_d = pa;
          state_d = S_WRITE;
        end else begin
          if (!pvalid_q[pa] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d = pa;
          end
          if (pidx_q == CW'(PEER_SLOTS - 1)) state_d = S_WRITE;
          else pidx_d = pidx_q + 1'b1;
        end
      end
      S_WRITE: begin
        pidx_d = '0;
        state_d = S_RANK;
        if (hit_q) begin
          peer_wr = 1'b1;
        end else if (free_found_q) begin
          peer_wr = 1'b1;
          peer_wa = free_idx_q;
          pvalid_d[free_idx_q] = 1'b1;
          hit_d = 1'b1;
          hit_idx_d = free_idx_q;
        end
      end
      S_RANK: begin
        if (pvalid_q[pa] && peer_lvl[pa] > job_q.lvl) stronger_d = stronger_q + 1'b1;
        if (pidx_q == CW'(PEER_SLOTS - 1)) state_d = S_DONE;
        else pidx_d = pidx_q + 1'b1;
      end
      S_DONE: begin
        acc_d.preferred = pref;
        if (job_q.hop <= 8'd1) acc_d.status = StHopExpired;
        else if (job_q.lvl < min_level_i) acc_d.status = StWeak;
        else if (!pref) acc_d.status = StNotPreferred;
        else begin
          acc_d.status = StForwarded;
          acc_d.forward = 1'b1;
          acc_d.new_hop = job_q.hop - 8'd1;
        end
        state_d = S_OUT;
      end
      S_CLEAN: begin
        if (pvalid_q[pa] && age > timeout_i) pvalid_d[pa] = 1'b0;
        if (pidx_q == CW'(PEER_SLOTS - 1)) state_d = S_OUT;
        else pidx_d = pidx_q + 1'b1;
      end
      S_OUT: begin
        if (!res_valid_q || res_ready_i) begin
          res_valid_d = 1'b1;
          res_d = acc_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      snext_q <= '0;
      svalid_q <= '0;
      pvalid_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      snext_q <= snext_d;
      svalid_q <= svalid_d;
      pvalid_q <= pvalid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sidx_q <= sidx_d;
    pidx_q <= pidx_d;
    hit_q <= hit_d;
    hit_idx_q <= hit_idx_d;
    free_found_q <= free_found_d;
    free_idx_q <= free_idx_d;
    stronger_q <= stronger_d;
    res_q <= res_d;
    acc_q <= acc_d;
    if (state_q == S_IDLE && job_valid_i) job_q <= job_i;
    if (seen_wr) begin
      seen_src[snext_q] <= job_q.call;
      seen_msg[snext_q] <= job_q.msg;
    end
    if (peer_wr) begin
      peer_call[peer_wa] <= job_q.call;
      peer_lvl[peer_wa] <= job_q.lvl;
      peer_time[peer_wa] <= job_q.t;
    end
  end

  a_fwd_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.forward == (res_q.status == StForwarded)))
    else $error("forward flag disagrees with status");
  a_fwd_pref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.forward) |-> res_q.preferred)
    else $error("forwarded without preference");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !job_ready_o)
    else $error("ready while busy");

endmodule

// ===== sv/mesh_forward_decision_core.sv =====
// ----------------------------------------------------------------------------
// mesh_forward_decision_core
// Forwarding decision for a flooding mesh node with duplicate cache.
// ----------------------------------------------------------------------------
// Items enter on the s_axis group and one result per item leaves on m_axis.
// s_axis_tdata holds source call, message id, hop limit, frame length,
// raw level and time; tuser carries cmd (0 frame, 1 cleanup tick).
// m_axis_tdata holds new hop limit, level in dBm and preferred; tuser holds
// status and forward. Registers are written through cfg_we_i at any edge.
// A one-entry front stage takes an item and hands it to the back part, which
// walks the seen ring (one entry a cycle) and the neighbor table (two passes
// of one entry a cycle); a duplicate ends its seen scan early. The back part's
// single scan engine takes a new item only once it has handed on the result
// of the last one. Reset empties the seen ring and the neighbor table at once.
// When the receiver stalls, the result is held in the output register while
// the back part finishes the next item and then waits; the front still takes
// one more item.
module mesh_forward_decision_core #(
  parameter int unsigned SEEN_DEPTH   = 32,
  parameter int unsigned PEER_SLOTS   = 20,
  parameter int unsigned HEADER_BYTES = 22
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // source_call, message_id, hop_limit, frame_length, raw_level, time_ms
  input  logic [127:0] s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_hop_limit, level_dbm, preferred, zero fill
  output logic [23:0]  m_axis_tdata,
  // status, forward
  output logic [3:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import mfd_pkg::*;

  logic signed [8:0] min_level_q;
  logic [4:0] top_count_q;
  logic [31:0] timeout_q;
  logic [7:0] offset_q;
  logic job_valid, job_ready, res_valid;
  job_t job;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q <= -9'sd105;
      top_count_q <= 5'd3;
      timeout_q <= 32'd60000;
      offset_q <= 8'd157;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMinLevel: min_level_q <= cfg_data_i[8:0];
        RegTopCount: top_count_q <= cfg_data_i[4:0];
        RegTimeout:  timeout_q <= cfg_data_i;
        RegOffset:   offset_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  mfd_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser), .call_i(s_axis_tdata[55:0]), .msg_i(s_axis_tdata[71:56]),
    .hop_i(s_axis_tdata[79:72]), .len_i(s_axis_tdata[87:80]),
    .raw_i(s_axis_tdata[95:88]), .time_i(s_axis_tdata[127:96]),
    .offset_i(offset_q),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  mfd_back #(.SEEN_DEPTH(SEEN_DEPTH), .PEER_SLOTS(PEER_SLOTS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .min_level_i(min_level_q), .top_count_i(top_count_q), .timeout_i(timeout_q),
    .res_valid_o(res_valid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {6'd0, res.preferred, res.lvl, res.new_hop};
  assign m_axis_tuser  = {res.forward, res.status};

endmodule
